>>> design/yrc_pkg.sv
// shared types and constants of the yuyv to rgba converter
// no dependencies; used by every module of the block
package yrc_pkg;

  localparam int BYTE_W     = 8;
  localparam int V_ORDER_W  = 1;
  localparam int WIDTH_W    = 13;
  localparam int STRIDE_W   = 14;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TERM_W = 18;
  localparam int ACC_W  = 20;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [BYTE_W-1:0] LUMA_OFFSET  = 8'd16;
  localparam logic [BYTE_W-1:0] CHROMA_MID   = 8'd128;

  localparam logic signed [TERM_W-1:0] COEF_Y  = 18'sd298;
  localparam logic signed [TERM_W-1:0] COEF_RV = 18'sd409;
  localparam logic signed [TERM_W-1:0] COEF_GU = 18'sd100;
  localparam logic signed [TERM_W-1:0] COEF_GV = 18'sd208;
  localparam logic signed [TERM_W-1:0] COEF_BU = 18'sd516;
  localparam logic signed [ACC_W-1:0]  ROUND   = 20'sd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_V_BEFORE_U = 2'd0,
    CFG_WIDTH      = 2'd1,
    CFG_STRIDE     = 2'd2,
    CFG_HEIGHT     = 2'd3
  } cfg_idx_e;

  // one chroma-sharing pixel pair, chroma already in u/v order
  typedef struct packed {
    logic [BYTE_W-1:0] y0;
    logic [BYTE_W-1:0] y1;
    logic [BYTE_W-1:0] u;
    logic [BYTE_W-1:0] v;
    logic              eol;
    logic              eof;
  } pair_t;

endpackage

>>> design/yrc_front.sv
// byte front end: config registers, line position tracking, pair assembly
// depends on yrc_pkg
module yrc_front #(
  parameter int MAX_STRIDE = 8192,
  parameter int MAX_LINES  = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           byte_valid_i,
  output logic                           byte_ready_o,
  input  logic [yrc_pkg::BYTE_W-1:0]     byte_i,
  input  logic                           cfg_valid_i,
  input  logic [yrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [yrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output yrc_pkg::pair_t                 pair_o
);

  localparam int POS_W  = $clog2(MAX_STRIDE);
  localparam int LINE_W = $clog2(MAX_LINES);
  localparam int CMP_W  = (POS_W + 1 > yrc_pkg::STRIDE_W) ? POS_W + 1 : yrc_pkg::STRIDE_W;
  localparam int LH_W   = (LINE_W + 1 > yrc_pkg::HEIGHT_W) ? LINE_W + 1 : yrc_pkg::HEIGHT_W;

  logic                             v_before_u_q;
  logic [yrc_pkg::WIDTH_W-1:0]      width_q;
  logic [yrc_pkg::STRIDE_W-1:0]     stride_q;
  logic [yrc_pkg::HEIGHT_W-1:0]     height_q;

  logic [POS_W-1:0]                 pos_q, pos_d;
  logic [LINE_W-1:0]                line_q, line_d;
  logic [yrc_pkg::BYTE_W-1:0]       y0_q, c0_q, y1_q;

  logic [CMP_W-1:0]                 stride_ext, stride_eff, active, act_w, pos_ext, pos_inc;
  logic [LH_W-1:0]                  height_ext, height_eff, line_inc;
  logic                             accept, in_active, last_line, line_end, eol;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_before_u_q <= 1'b0;
      width_q      <= 13'd1800;
      stride_q     <= 14'd3600;
      height_q     <= 13'd900;
    end else if (cfg_valid_i) begin
      case (yrc_pkg::cfg_idx_e'(cfg_index_i))
        yrc_pkg::CFG_V_BEFORE_U: v_before_u_q <= cfg_data_i[0];
        yrc_pkg::CFG_WIDTH:      width_q      <= cfg_data_i[yrc_pkg::WIDTH_W-1:0];
        yrc_pkg::CFG_STRIDE:     stride_q     <= cfg_data_i[yrc_pkg::STRIDE_W-1:0];
        yrc_pkg::CFG_HEIGHT:     height_q     <= cfg_data_i[yrc_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stride_ext = CMP_W'(stride_q);
    if (stride_ext > CMP_W'(MAX_STRIDE)) begin
      stride_eff = CMP_W'(MAX_STRIDE);
    end else if (stride_ext == '0) begin
      stride_eff = CMP_W'(1);
    end else begin
      stride_eff = stride_ext;
    end
    height_ext = LH_W'(height_q);
    if (height_ext > LH_W'(MAX_LINES)) begin
      height_eff = LH_W'(MAX_LINES);
    end else if (height_ext == '0) begin
      height_eff = LH_W'(1);
    end else begin
      height_eff = height_ext;
    end
    // active bytes: twice the even width, limited to whole groups in the stride
    act_w  = CMP_W'({width_q[yrc_pkg::WIDTH_W-1:1], 2'b00});
    active = (act_w > {stride_eff[CMP_W-1:2], 2'b00}) ? {stride_eff[CMP_W-1:2], 2'b00} : act_w;
    pos_ext   = CMP_W'(pos_q);
    pos_inc   = pos_ext + CMP_W'(1);
    line_inc  = LH_W'(line_q) + LH_W'(1);
    in_active = pos_ext < active;
    last_line = line_inc >= height_eff;
    line_end  = pos_inc >= stride_eff;
    eol       = pos_inc == active;
    pos_d  = line_end ? '0 : pos_inc[POS_W-1:0];
    line_d = line_end ? (last_line ? '0 : line_inc[LINE_W-1:0]) : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      line_q <= '0;
      y0_q   <= '0;
      c0_q   <= '0;
      y1_q   <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      line_q <= line_d;
      if (in_active) begin
        case (pos_q[1:0])
          2'd0:    y0_q <= byte_i;
          2'd1:    c0_q <= byte_i;
          2'd2:    y1_q <= byte_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    push_o     = accept && in_active && (pos_q[1:0] == 2'd3);
    pair_o.y0  = y0_q;
    pair_o.y1  = y1_q;
    pair_o.u   = v_before_u_q ? byte_i : c0_q;
    pair_o.v   = v_before_u_q ? c0_q : byte_i;
    pair_o.eol = eol;
    pair_o.eof = eol && last_line;
  end

endmodule

>>> design/yrc_fifo.sv
// short pair queue between the byte front end and the pixel back end
// depends on yrc_pkg
module yrc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  yrc_pkg::pair_t pair_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output yrc_pkg::pair_t pair_o
);

  yrc_pkg::pair_t                  mem_q [yrc_pkg::QUEUE_DEPTH];
  logic [yrc_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [yrc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = cnt_q == yrc_pkg::QCNT_W'(yrc_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pair_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + yrc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - yrc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (32'(wr_q) == yrc_pkg::QUEUE_DEPTH - 1) ? '0 : wr_q + yrc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == yrc_pkg::QUEUE_DEPTH - 1) ? '0 : rd_q + yrc_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= pair_i;
    end
  end

endmodule

>>> design/yrc_back.sv
// pixel back end: splits each pair into two pixels, bt.601 products, sum and clip
// depends on yrc_pkg
module yrc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  yrc_pkg::pair_t                pair_i,
  output logic                          pop_o,
  output logic                          pix_valid_o,
  input  logic                          pix_ready_i,
  output logic [4*yrc_pkg::BYTE_W-1:0]  pix_data_o,
  output logic                          pix_last_o,
  output logic [1:0]                    pix_flags_o
);

  function automatic logic [yrc_pkg::BYTE_W-1:0] clip8(logic signed [yrc_pkg::ACC_W-1:0] acc);
    logic [yrc_pkg::BYTE_W-1:0] res;
    if (acc[yrc_pkg::ACC_W-1]) begin
      res = '0;
    end else if (|acc[yrc_pkg::ACC_W-2:16]) begin
      res = 8'hff;
    end else begin
      res = acc[15:8];
    end
    return res;
  endfunction

  logic                                phase_q;
  logic                                s1_valid_q, out_valid_q;
  logic                                en1, en2, issue;
  logic signed [8:0]                   c, d, e;
  logic signed [yrc_pkg::TERM_W-1:0]   yt_q, bt_q, gt_q, rt_q;
  logic                                s1_last_q, s1_eol_q, s1_eof_q;
  logic [yrc_pkg::BYTE_W-1:0]          blue_q, green_q, red_q;
  logic                                last_q, eol_q, eof_q;
  logic signed [yrc_pkg::ACC_W-1:0]    acc_b, acc_g, acc_r;

  assign en2   = !out_valid_q || pix_ready_i;
  assign en1   = !s1_valid_q || en2;
  assign issue = !empty_i && en1;
  assign pop_o = issue && phase_q;

  always_comb begin
    c = $signed({1'b0, phase_q ? pair_i.y1 : pair_i.y0}) - $signed({1'b0, yrc_pkg::LUMA_OFFSET});
    d = $signed({1'b0, pair_i.u}) - $signed({1'b0, yrc_pkg::CHROMA_MID});
    e = $signed({1'b0, pair_i.v}) - $signed({1'b0, yrc_pkg::CHROMA_MID});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        phase_q <= !phase_q;
      end
      if (en1) begin
        s1_valid_q <= !empty_i;
      end
      if (en2) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      yt_q      <= yrc_pkg::TERM_W'(c) * yrc_pkg::COEF_Y;
      bt_q      <= yrc_pkg::TERM_W'(d) * yrc_pkg::COEF_BU;
      gt_q      <= -(yrc_pkg::TERM_W'(d) * yrc_pkg::COEF_GU
                     + yrc_pkg::TERM_W'(e) * yrc_pkg::COEF_GV);
      rt_q      <= yrc_pkg::TERM_W'(e) * yrc_pkg::COEF_RV;
      s1_last_q <= phase_q;
      s1_eol_q  <= phase_q && pair_i.eol;
      s1_eof_q  <= phase_q && pair_i.eof;
    end
  end

  always_comb begin
    acc_b = yrc_pkg::ACC_W'(yt_q) + yrc_pkg::ACC_W'(bt_q) + yrc_pkg::ROUND;
    acc_g = yrc_pkg::ACC_W'(yt_q) + yrc_pkg::ACC_W'(gt_q) + yrc_pkg::ROUND;
    acc_r = yrc_pkg::ACC_W'(yt_q) + yrc_pkg::ACC_W'(rt_q) + yrc_pkg::ROUND;
  end

  // sum, clip and output register
  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      blue_q  <= clip8(acc_b);
      green_q <= clip8(acc_g);
      red_q   <= clip8(acc_r);
      last_q  <= s1_last_q;
      eol_q   <= s1_eol_q;
      eof_q   <= s1_eof_q;
    end
  end

  assign pix_valid_o = out_valid_q;
  assign pix_data_o  = {yrc_pkg::ALPHA_OPAQUE, red_q, green_q, blue_q};
  assign pix_last_o  = last_q;
  assign pix_flags_o = {eof_q, eol_q};

endmodule

>>> design/yuyv_to_rgba_converter_core.sv
// top level of the packed 4:2:2 to rgba converter
// depends on yrc_pkg, yrc_front, yrc_fifo, yrc_back
//
// usage
//   s_axis carries one byte of the yuyv (or yvyu) stream per word.
//   m_axis carries one rgba pixel per word; two pixels follow every fourth
//   active byte of a line, tlast marks the second pixel of each pair and
//   tuser flags end of line and end of frame on that pixel.
//   cfg writes one register per word: 0 chroma order, 1 width in pixels,
//   2 stride in bytes, 3 height in lines; write only while the block is idle.
// flow
//   one byte per cycle in while the pair queue has room; after the fourth byte
//   is taken, each pixel of the pair passes the pair queue, the product stage
//   and the output register, the second pixel right behind the first; the back
//   end drains pairs faster than the front end assembles them.
// reset
//   clears position, line count and queue; registers return to defaults.
// stall
//   a stalled m_axis holds its pixel; the queue fills and s_axis_tready
//   drops only when two pairs are waiting.
module yuyv_to_rgba_converter_core #(
  parameter int MAX_STRIDE = 8192,
  parameter int MAX_LINES  = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // yuv_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // blue, green, red, alpha
  output logic                           m_axis_tlast,
  output logic [1:0]                     m_axis_tuser,  // end_of_line, end_of_frame
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [yrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [yrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic           push, pop, full, empty;
  yrc_pkg::pair_t pair_in, pair_out;

  assign cfg_ready_o = 1'b1;

  yrc_front #(
    .MAX_STRIDE(MAX_STRIDE),
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid),
    .byte_ready_o(s_axis_tready),
    .byte_i      (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .queue_full_i(full),
    .push_o      (push),
    .pair_o      (pair_in)
  );

  yrc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pair_i (pair_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .pair_o (pair_out)
  );

  yrc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pair_i     (pair_out),
    .pop_o      (pop),
    .pix_valid_o(m_axis_tvalid),
    .pix_ready_i(m_axis_tready),
    .pix_data_o (m_axis_tdata),
    .pix_last_o (m_axis_tlast),
    .pix_flags_o(m_axis_tuser)
  );

endmodule

>>> design/yrc_checker.sv
// port-level checks for the converter top level, attached by bind
// depends on yrc_pkg and yuyv_to_rgba_converter_core
module yrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // every pixel is opaque
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:24] == yrc_pkg::ALPHA_OPAQUE)
    else $error("alpha not opaque");

  // line and frame flags only on the second pixel, frame end only at line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != 2'b00) |-> m_axis_tlast && m_axis_tuser[0])
    else $error("flags on wrong pixel");

  // second pixel of a pair follows right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("pair split");

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled word changed");

endmodule

bind yuyv_to_rgba_converter_core yrc_checker u_yrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
